// ===== src/display_dirty_span_tracker_unit_defines.svh =====
// ---------------------------------------------------------------------------
// display_dirty_span_tracker_unit_defines
// assertion macros shared by the dirty span tracker rtl
// ---------------------------------------------------------------------------
`ifndef DISPLAY_DIRTY_SPAN_TRACKER_UNIT_DEFINES_SVH
`define DISPLAY_DIRTY_SPAN_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk with reset masking
`define DDST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DDST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ddst_pkg.sv =====
// ---------------------------------------------------------------------------
// ddst_pkg
// types and constants of the display dirty span tracker
// ---------------------------------------------------------------------------
package ddst_pkg;

  localparam logic       OP_WRITE     = 1'b0;
  localparam logic       OP_READ      = 1'b1;
  localparam logic       KIND_SPAN    = 1'b0;
  localparam logic       KIND_READ    = 1'b1;
  localparam logic       REG_COLUMNS  = 1'b0;
  localparam logic       REG_PAGES    = 1'b1;
  localparam logic [7:0] COLS_RESET   = 8'd128;
  localparam logic [3:0] PAGES_RESET  = 4'd8;
  localparam logic [7:0] REUSE_SLACK  = 8'd4;
  localparam logic [7:0] SHADOW_INIT  = 8'hFF;

  typedef struct packed {
    logic       op;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] pixel_byte;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic       set_column;
    logic [6:0] first_col;
    logic [6:0] last_col;
    logic       set_page;
    logic [2:0] span_page;
    logic [2:0] page_end;
    logic [7:0] read_byte;
  } out_word_t;

  // per-item control from the pipeline to the span tracker
  typedef struct packed {
    logic       fire;
    logic       in_panel;
    logic       last_col;
    logic [2:0] page_end;
  } span_ctl_t;

endpackage

// ===== src/ddst_stream_if.sv =====
// ---------------------------------------------------------------------------
// ddst_stream_if
// valid/ready channels for framebuffer words in and result words out
// ---------------------------------------------------------------------------
interface ddst_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] page;
  logic [6:0] column;
  logic [7:0] pixel_byte;

  modport source (output valid, op, page, column, pixel_byte, input ready);
  modport sink   (input valid, op, page, column, pixel_byte, output ready);
endinterface

interface ddst_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       set_column;
  logic [6:0] first_col;
  logic [6:0] last_col;
  logic       set_page;
  logic [2:0] span_page;
  logic [2:0] page_end;
  logic [7:0] read_byte;

  modport source (output valid, kind, set_column, first_col, last_col, set_page,
                  span_page, page_end, read_byte, input ready);
  modport sink   (input valid, kind, set_column, first_col, last_col, set_page,
                  span_page, page_end, read_byte, output ready);
endinterface

// ===== src/display_dirty_span_tracker_unit.sv =====
// ---------------------------------------------------------------------------
// display_dirty_span_tracker_unit
// shadow buffer dirty span tracker for a 1-bit paged display
// ---------------------------------------------------------------------------
// Takes one word per cycle once the shadow memory is ready, unless a held
// result stalls the input. After reset the shadow memory is swept to 0xFF,
// one entry per cycle, over all MAX_PAGES * MAX_COLUMNS entries (1024 by
// default) with in_ch.ready low; configuration writes are taken during that
// time. Each word then passes two steps: the first reads its shadow byte
// from the single-port-read memory, the second compares, updates the span
// state and writes the byte back, with a bypass when back-to-back words hit
// the same entry. A result passes the stage register into the output
// register and waits there for out_ch.ready while one more word may enter.
`include "display_dirty_span_tracker_unit_defines.svh"

module display_dirty_span_tracker_unit
  import ddst_pkg::*;
#(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_PAGES   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  ddst_in_if.sink           in_ch,
  ddst_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int DEPTH = MAX_PAGES * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    cols_r;
  logic [3:0]    pages_r;
  logic [7:0]    w_eff;
  logic [3:0]    p_eff;
  logic          cfg_wr;

  in_word_t      in_word;
  logic          in_fire;
  logic [AW-1:0] in_addr;

  logic          s1_valid_r;
  in_word_t      s1_item_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_fire;
  span_ctl_t     ctl;

  logic          out_valid_r;
  out_word_t     out_r;
  logic          out_free;

  logic [7:0]    shadow_byte;
  logic          clr_done;
  logic          shadow_wr;
  logic          res_valid;
  out_word_t     res;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= COLS_RESET;
      pages_r <= PAGES_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_COLUMNS: cols_r  <= cfg_pwdata[7:0];
        REG_PAGES:   pages_r <= cfg_pwdata[3:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_COLUMNS: cfg_prdata = {24'd0, cols_r};
      REG_PAGES:   cfg_prdata = {28'd0, pages_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // register values saturated into the supported range
  always_comb begin
    priority if (cols_r == 8'd0)               w_eff = 8'd1;
    else if (cols_r > 8'(MAX_COLUMNS))         w_eff = 8'(MAX_COLUMNS);
    else                                       w_eff = cols_r;
    priority if (pages_r == 4'd0)              p_eff = 4'd1;
    else if (pages_r > 4'(MAX_PAGES))          p_eff = 4'(MAX_PAGES);
    else                                       p_eff = pages_r;
  end

  // input stage: issue the shadow read
  assign in_word.op         = in_ch.op;
  assign in_word.page       = in_ch.page;
  assign in_word.column     = in_ch.column;
  assign in_word.pixel_byte = in_ch.pixel_byte;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = clr_done && (!s1_valid_r || out_free);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_addr     = AW'(int'(in_word.page) * MAX_COLUMNS + int'(in_word.column));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_word;
      s1_addr_r <= in_addr;
    end
  end

  // compare stage
  always_comb begin
    ctl.fire     = s1_fire;
    ctl.in_panel = ({1'b0, s1_item_r.column} < w_eff) &&
                   ({1'b0, s1_item_r.page} < p_eff);
    ctl.last_col = {1'b0, s1_item_r.column} == (w_eff - 8'd1);
    ctl.page_end = 3'(p_eff - 4'd1);
  end

  assign shadow_wr = s1_fire && (s1_item_r.op == OP_WRITE) && ctl.in_panel;

  ddst_shadow_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (in_addr),
    .rd_data  (shadow_byte),
    .wr_en    (shadow_wr),
    .wr_addr  (s1_addr_r),
    .wr_data  (s1_item_r.pixel_byte),
    .clr_done (clr_done)
  );

  ddst_span_track u_span (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .item        (s1_item_r),
    .shadow_byte (shadow_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.set_column = out_r.set_column;
  assign out_ch.first_col  = out_r.first_col;
  assign out_ch.last_col   = out_r.last_col;
  assign out_ch.set_page   = out_r.set_page;
  assign out_ch.span_page  = out_r.span_page;
  assign out_ch.page_end   = out_r.page_end;
  assign out_ch.read_byte  = out_r.read_byte;

  `DDST_ASSERT_SAME(a_no_word_during_clear, in_ch.ready, clr_done, "word taken during clear")
  `DDST_ASSERT_NEXT(a_result_lands, s1_fire && res_valid, out_valid_r, "result word dropped")
  `DDST_ASSERT_SAME(a_write_from_byte_op, shadow_wr, (s1_item_r.op == OP_WRITE) && clr_done,
                    "shadow write from a read word")

endmodule

// ===== src/ddst_shadow_mem.sv =====
// ---------------------------------------------------------------------------
// ddst_shadow_mem
// shadow copy of panel memory: one write and one registered read per cycle,
// clearing pass to 0xFF after reset, write-to-read forwarding
// ---------------------------------------------------------------------------
module ddst_shadow_mem
  import ddst_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          clr_done
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    q_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_done_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;

  assign we = !clr_done_r || wr_en;
  assign wa = clr_done_r ? wr_addr : clr_cnt_r;
  assign wd = clr_done_r ? wr_data : SHADOW_INIT;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (!clr_done_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_done_r <= 1'b1;
        end
      end
      // a read that meets a write to the same entry sees the new byte
      if (rd_en) begin
        fwd_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data  = fwd_r ? fwd_data_r : q_r;
  assign clr_done = clr_done_r;

endmodule

// ===== src/ddst_span_track.sv =====
// ---------------------------------------------------------------------------
// ddst_span_track
// compares a word with its shadow byte, tracks the changed span of a page
// and builds span descriptors and shadow read results
// ---------------------------------------------------------------------------
module ddst_span_track
  import ddst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  span_ctl_t ctl,
  input  in_word_t  item,
  input  logic [7:0] shadow_byte,
  output logic      res_valid,
  output out_word_t res
);

  logic [7:0] span_start_r;
  logic [6:0] span_stop_r;
  logic       win_valid_r;
  logic [6:0] win_first_r;
  logic [6:0] win_last_r;
  logic       exp_valid_r;
  logic [3:0] exp_page_r;

  logic       upd;
  logic       frame;
  logic       wv;
  logic       ev;
  logic [7:0] ss;
  logic [7:0] ss2;
  logic [6:0] stop2;
  logic       changed;
  logic       emit;
  logic [6:0] first;
  logic       reuse;
  logic       set_pg;

  always_comb begin
    upd     = ctl.fire && (item.op == OP_WRITE) && ctl.in_panel;
    frame   = (item.page == 3'd0) && (item.column == 7'd0);
    wv      = win_valid_r && !frame;
    ev      = exp_valid_r && !frame;
    ss      = (item.column == 7'd0) ? 8'd0 : span_start_r;
    changed = shadow_byte != item.pixel_byte;
    ss2     = (changed && ss == 8'd0) ? ({1'b0, item.column} + 8'd1) : ss;
    stop2   = changed ? item.column : span_stop_r;
    emit    = ctl.in_panel && ctl.last_col && (ss2 != 8'd0);
    first   = 7'(ss2 - 8'd1);
    // keep the old window when the new span sits just inside both ends
    reuse   = wv && (first > win_first_r) &&
              ({1'b0, first} <= {1'b0, win_first_r} + REUSE_SLACK) &&
              (stop2 < win_last_r) &&
              ({1'b0, stop2} + REUSE_SLACK >= {1'b0, win_last_r});
    set_pg  = !(ev && ({1'b0, item.page} == exp_page_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_start_r <= '0;
      span_stop_r  <= '0;
      win_valid_r  <= 1'b0;
      win_first_r  <= '0;
      win_last_r   <= '0;
      exp_valid_r  <= 1'b0;
      exp_page_r   <= '0;
    end else if (upd) begin
      span_stop_r <= stop2;
      if (emit) begin
        // a descriptor always leaves a window and a page behind
        span_start_r <= '0;
        win_valid_r  <= 1'b1;
        exp_valid_r  <= 1'b1;
        exp_page_r   <= {1'b0, item.page} + 4'd1;
        if (!reuse) begin
          win_first_r <= first;
          win_last_r  <= stop2;
        end
      end else begin
        span_start_r <= ss2;
        win_valid_r  <= wv;
        exp_valid_r  <= ev;
      end
    end
  end

  always_comb begin
    res = '0;
    if (item.op == OP_READ) begin
      res_valid     = 1'b1;
      res.kind      = KIND_READ;
      res.read_byte = ctl.in_panel ? shadow_byte : 8'd0;
    end else begin
      res_valid      = emit;
      res.kind       = KIND_SPAN;
      res.set_column = !reuse;
      res.first_col  = reuse ? win_first_r : first;
      res.last_col   = reuse ? win_last_r : stop2;
      res.set_page   = set_pg;
      res.span_page  = item.page;
      res.page_end   = ctl.page_end;
    end
  end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the display dirty span tracker
// ---------------------------------------------------------------------------
// A clocked driver feeds framebuffer and shadow-read words from a queue that
// the stimulus process fills in phases. Each phase first sets the display
// size over the cfg port. A clocked monitor compares every result word with
// the oldest prediction from an in-bench shadow memory and span tracker. Both
// channel sides idle in random bursts, and the receiver holds off once for a
// long stretch so that the block stalls its input.
module tb;
  import ddst_pkg::*;

  localparam int DISPLAY_COLUMNS = 128;
  localparam int DISPLAY_PAGES   = 8;
  localparam int LONG_HOLD       = 60;
  localparam int SETTLE_CYCLES   = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ddst_in_if  in_ch ();
  ddst_out_if out_ch ();

  display_dirty_span_tracker_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bench copy of the block state
  logic [7:0] shadow_mirror [0:1023];
  logic [7:0] gen_shadow    [0:1023];
  int         dirty_start;
  int         dirty_stop;
  int         win_first;
  int         win_last;
  int         next_page;
  logic [7:0] cols_reg;
  logic [3:0] pages_reg;

  in_word_t  framebuffer_words [$];
  out_word_t expected_results [$];
  int        words_queued;
  int        words_accepted;
  int        mismatch_count;
  logic      calm;
  logic      long_hold_req;

  function automatic int eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > DISPLAY_COLUMNS) return DISPLAY_COLUMNS;
    return int'(cols_reg);
  endfunction

  function automatic int eff_pages();
    if (pages_reg == 0) return 1;
    if (pages_reg > DISPLAY_PAGES) return DISPLAY_PAGES;
    return int'(pages_reg);
  endfunction

  function automatic void predict_span_result(input in_word_t w, output bit has_result,
                                              output out_word_t res);
    int         wid;
    int         pgs;
    int         span_first;
    int         span_last;
    bit         inside_panel;
    bit         keep;
    logic [9:0] a;
    res = '0;
    has_result = 1'b0;
    wid = eff_cols();
    pgs = eff_pages();
    inside_panel = (int'(w.column) < wid) && (int'(w.page) < pgs);
    a = {w.page, w.column};
    if (w.op == OP_READ) begin
      res.kind = KIND_READ;
      res.read_byte = inside_panel ? shadow_mirror[a] : 8'h00;
      has_result = 1'b1;
      return;
    end
    if (!inside_panel) return;
    // frame start forgets the window and the page
    if (w.page == 0 && w.column == 0) begin
      win_first = -1;
      win_last = -1;
      next_page = -1;
    end
    if (w.column == 0) dirty_start = 0;
    if (shadow_mirror[a] != w.pixel_byte) begin
      if (dirty_start == 0) dirty_start = int'(w.column) + 1;
      dirty_stop = int'(w.column);
    end
    shadow_mirror[a] = w.pixel_byte;
    if (int'(w.column) != wid - 1 || dirty_start == 0) return;
    span_first = dirty_start - 1;
    span_last = dirty_stop;
    keep = span_first > win_first && span_first <= win_first + int'(REUSE_SLACK) &&
           span_last < win_last && span_last >= win_last - int'(REUSE_SLACK);
    if (keep) begin
      span_first = win_first;
      span_last = win_last;
    end else begin
      win_first = span_first;
      win_last = span_last;
    end
    res.kind = KIND_SPAN;
    res.set_column = !keep;
    res.first_col = span_first[6:0];
    res.last_col = span_last[6:0];
    res.set_page = (int'(w.page) != next_page);
    res.span_page = w.page;
    res.page_end = 3'(pgs - 1);
    next_page = int'(w.page) + 1;
    dirty_start = 0;
    has_result = 1'b1;
  endfunction

  function automatic string word_text(input out_word_t r);
    return $sformatf("kind=%0d set_col=%0d cols=%0d..%0d set_page=%0d page=%0d end=%0d byte=%02h",
                     r.kind, r.set_column, r.first_col, r.last_col, r.set_page,
                     r.span_page, r.page_end, r.read_byte);
  endfunction

  // driver: one word per handshake, random idle bursts
  in_word_t  word_on_bus;
  int        src_gap;
  bit        src_has_result;
  out_word_t src_result;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_span_result(word_on_bus, src_has_result, src_result);
        if (src_has_result) expected_results.push_back(src_result);
        words_accepted = words_accepted + 1;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (src_gap > 0) begin
          in_ch.valid <= 1'b0;
          src_gap = src_gap - 1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          in_ch.valid <= 1'b0;
          src_gap = $urandom_range(0, 8);
        end else if (framebuffer_words.size() > 0) begin
          word_on_bus = framebuffer_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= word_on_bus.op;
          in_ch.page <= word_on_bus.page;
          in_ch.column <= word_on_bus.column;
          in_ch.pixel_byte <= word_on_bus.pixel_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  out_word_t got;
  out_word_t want;
  int        sink_gap;
  int        hold_left;
  logic      long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.set_column = out_ch.set_column;
        got.first_col = out_ch.first_col;
        got.last_col = out_ch.last_col;
        got.set_page = out_ch.set_page;
        got.span_page = out_ch.span_page;
        got.page_end = out_ch.page_end;
        got.read_byte = out_ch.read_byte;
        if (expected_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("%0t: result word with nothing expected: %s", $realtime, word_text(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("%0t: result word differs", $realtime);
              $display("  expected %s", word_text(want));
              $display("  actual   %s", word_text(got));
            end
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_word(input logic op, input logic [2:0] page, input logic [6:0] column,
                            input logic [7:0] pixel_byte);
    in_word_t w;
    w.op = op;
    w.page = page;
    w.column = column;
    w.pixel_byte = pixel_byte;
    framebuffer_words.push_back(w);
    words_queued = words_queued + 1;
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_display_size(input logic [7:0] cols, input logic [3:0] pages);
    write_register({REG_COLUMNS, 2'b00}, {24'd0, cols});
    cols_reg = cols;
    write_register({REG_PAGES, 2'b00}, {28'd0, pages});
    pages_reg = pages;
  endtask

  task automatic wait_until_idle();
    while (words_accepted != words_queued || expected_results.size() != 0) @(posedge clk);
    // words that make no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // raster-ordered pages with chosen dirty spans, plus reads, noise and jumps
  task automatic add_raster_words(input int n);
    int         w;
    int         p;
    int         pg;
    int         col;
    int         lo;
    int         hi;
    int         prev_lo;
    int         prev_hi;
    int         sel;
    int         r;
    int         done;
    logic [2:0] npg;
    logic [6:0] ncol;
    logic [7:0] b;
    logic [9:0] a;
    w = eff_cols();
    p = eff_pages();
    pg = 0;
    col = 0;
    lo = 0;
    hi = w - 1;
    prev_lo = 0;
    prev_hi = w - 1;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        if ($urandom_range(0, 3) != 0)
          queue_word(OP_READ, 3'($urandom_range(0, p - 1)), 7'($urandom_range(0, w - 1)),
                     8'($urandom));
        else
          queue_word(OP_READ, 3'($urandom), 7'($urandom), 8'($urandom));
        done = done + 1;
      end else if (r < 14) begin
        npg = 3'($urandom);
        ncol = 7'($urandom);
        b = 8'($urandom);
        queue_word(OP_WRITE, npg, ncol, b);
        if (int'(ncol) < w && int'(npg) < p) begin
          gen_shadow[{npg, ncol}] = b;
          done = done + 1;
        end
      end else if (r < 17) begin
        // broken sequence: jump within the page
        col = $urandom_range(0, w - 1);
      end else begin
        if (col == 0) begin
          sel = $urandom_range(0, 9);
          if (sel < 2) begin
            lo = w;
            hi = -1;
          end else if (sel < 6) begin
            // aim just inside the last window so it can be kept
            lo = prev_lo + $urandom_range(1, 4);
            hi = prev_hi - $urandom_range(1, 4);
            if (lo > hi) begin
              lo = prev_lo;
              hi = prev_hi;
            end
          end else begin
            lo = $urandom_range(0, w - 1);
            hi = $urandom_range(lo, w - 1);
            prev_lo = lo;
            prev_hi = hi;
          end
        end
        a = {3'(pg), 7'(col)};
        if (col == lo || col == hi) b = ~gen_shadow[a];
        else if (col > lo && col < hi) b = 8'($urandom);
        else b = gen_shadow[a];
        queue_word(OP_WRITE, 3'(pg), 7'(col), b);
        gen_shadow[a] = b;
        done = done + 1;
        col = col + 1;
        if (col >= w) begin
          col = 0;
          pg = (pg + 1) % p;
        end
      end
    end
  endtask

  task automatic run_raster_phase(input logic [7:0] cols, input logic [3:0] pages, input int n);
    wait_until_idle();
    set_display_size(cols, pages);
    gen_shadow = shadow_mirror;
    add_raster_words(n);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.page = '0;
    in_ch.column = '0;
    in_ch.pixel_byte = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    words_queued = 0;
    words_accepted = 0;
    mismatch_count = 0;
    for (int i = 0; i < 1024; i++) shadow_mirror[i] = SHADOW_INIT;
    dirty_start = 0;
    dirty_stop = 0;
    win_first = -1;
    win_last = -1;
    next_page = -1;
    cols_reg = COLS_RESET;
    pages_reg = PAGES_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 4 columns x 2 pages, queued while the shadow is still being cleared
    set_display_size(8'd4, 4'd2);
    queue_word(OP_READ, 3'd0, 7'd0, 8'h00);
    queue_word(OP_WRITE, 3'd0, 7'd0, 8'h00);
    queue_word(OP_WRITE, 3'd0, 7'd1, 8'h5A);
    queue_word(OP_WRITE, 3'd0, 7'd2, 8'hA5);
    queue_word(OP_WRITE, 3'd0, 7'd3, 8'h00);
    // span 1..2 sits inside 0..3: window kept, page auto-increments
    queue_word(OP_WRITE, 3'd1, 7'd0, 8'hFF);
    queue_word(OP_WRITE, 3'd1, 7'd1, 8'h00);
    queue_word(OP_WRITE, 3'd1, 7'd2, 8'h7F);
    queue_word(OP_WRITE, 3'd1, 7'd3, 8'hFF);
    // outside the panel: ignored writes and a zero read, then a read from inside
    queue_word(OP_WRITE, 3'd2, 7'd0, 8'h00);
    queue_word(OP_WRITE, 3'd0, 7'd4, 8'h00);
    queue_word(OP_WRITE, 3'd7, 7'd127, 8'hFF);
    queue_word(OP_READ, 3'd7, 7'd127, 8'hFF);
    queue_word(OP_READ, 3'd1, 7'd2, 8'hFF);
    // new frame with no change, then a full span that must reissue commands
    queue_word(OP_WRITE, 3'd0, 7'd0, 8'h00);
    queue_word(OP_WRITE, 3'd0, 7'd1, 8'h5A);
    queue_word(OP_WRITE, 3'd0, 7'd2, 8'hA5);
    queue_word(OP_WRITE, 3'd0, 7'd3, 8'h00);
    queue_word(OP_WRITE, 3'd1, 7'd0, 8'h00);
    queue_word(OP_WRITE, 3'd1, 7'd1, 8'h00);
    queue_word(OP_WRITE, 3'd1, 7'd2, 8'h7F);
    queue_word(OP_WRITE, 3'd1, 7'd3, 8'h00);
    queue_word(OP_READ, 3'd0, 7'd3, 8'h00);
    queue_word(OP_READ, 3'd1, 7'd0, 8'h00);

    // zero registers saturate to a single column and page
    run_raster_phase(8'd0, 4'd0, 40);
    run_raster_phase(8'd3, 4'd3, 60);
    long_hold_req <= 1'b1;
    // oversized registers saturate to the full panel
    run_raster_phase(8'd255, 4'd15, 150);
    run_raster_phase(8'd2, 4'd8, 50);
    run_raster_phase(8'($urandom_range(1, 12)), 4'($urandom_range(1, 8)), 60);
    wait_until_idle();
    calm <= 1'b1;
    run_raster_phase(8'd6, 4'd9, 60);

    wait_until_idle();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
